// ===== hdl/ethernet_protocol_counter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the protocol counter checkers.
// ----------------------------------------------------------------------------
`ifndef ETHERNET_PROTOCOL_COUNTER_ASSERT_SVH
`define ETHERNET_PROTOCOL_COUNTER_ASSERT_SVH

// same-cycle implication
`define EPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define EPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/epc_pkg.sv =====
// ----------------------------------------------------------------------------
// epc_pkg
// Types and constants of the per-protocol packet counter.
// ----------------------------------------------------------------------------
package epc_pkg;

    localparam int MAX_TAGS_DEF   = 2;
    localparam int COUNT_BITS_DEF = 64;

    localparam int ETH_HDR_LEN = 14;
    localparam int TAG_LEN     = 4;
    localparam int IPV4_PROTO_OFS = 9;
    localparam int IPV6_NH_OFS    = 6;
    localparam int IPV4_HDR_LEN   = 20;
    localparam int IPV6_HDR_LEN   = 40;

    localparam int OFS_W   = 7;
    localparam int TAG_W   = 2;
    localparam int NUM_CNT = 256;

    localparam int CMD_Q_DEPTH = 4;
    localparam int RES_Q_DEPTH = 2;

    localparam logic [15:0] ET_VLAN = 16'h8100;
    localparam logic [15:0] ET_QINQ = 16'h88A8;
    localparam logic [15:0] ET_IPV4 = 16'h0800;
    localparam logic [15:0] ET_IPV6 = 16'h86DD;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic RES_VERDICT = 1'b0;
    localparam logic RES_READ    = 1'b1;

    localparam logic [2:0] ACTION_RESET = 3'd1;

    typedef enum logic [1:0] {
        CMD_COUNT,
        CMD_SKIP,
        CMD_READ
    } cmd_kind_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
        logic       last_byte;
        logic [7:0] counter_index;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [2:0]  verdict;
        logic        was_counted;
        logic [7:0]  protocol_index;
        logic [63:0] count_value;
    } out_item_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] idx;
        logic [2:0] verdict;
    } cmd_t;

    function automatic logic is_tag(input logic [15:0] et);
        return (et == ET_VLAN) || (et == ET_QINQ);
    endfunction

endpackage

// ===== hdl/epc_fifo.sv =====
// ----------------------------------------------------------------------------
// epc_fifo
// Small register queue used between the front and back and at the output.
// ----------------------------------------------------------------------------
module epc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wptr_reg] <= wdata;
        end
    end

endmodule

// ===== hdl/epc_front.sv =====
// ----------------------------------------------------------------------------
// epc_front
// Byte parser: tracks ethertype and tags, captures the IP protocol byte and
// issues one command per packet end or counter read.
// ----------------------------------------------------------------------------
module epc_front
    import epc_pkg::*;
#(
    parameter int MAX_TAGS = MAX_TAGS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t in_data,
    input  logic     cfg_valid,
    input  logic [2:0] cfg_data,
    output logic     cmd_push,
    output cmd_t     cmd,
    input  logic     cmd_full
);

    logic [OFS_W-1:0] ofs_reg, ofs_next;
    logic [15:0]      et_reg, et_next;
    logic [TAG_W-1:0] tags_reg, tags_next;
    logic [OFS_W-1:0] hs_reg, hs_next;
    logic [7:0]       proto_reg, proto_next;
    logic [7:0]       prev_reg, prev_next;
    logic [2:0]       action_reg;

    logic [7:0] p;
    logic [7:0] hs_wide;
    logic [7:0] hs_nwide;
    logic       accept;
    logic       pend_cur, pend_new;
    logic       too_short;
    logic [7:0] pkt_idx;
    logic [15:0] et_upd;
    logic [TAG_W-1:0] tags_upd;
    logic [OFS_W-1:0] hs_upd;
    logic [7:0]  proto_upd;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;
    assign p        = {1'b0, ofs_reg};
    assign hs_wide  = {1'b0, hs_reg};

    always_comb
    begin
        et_upd    = et_reg;
        tags_upd  = tags_reg;
        hs_upd    = hs_reg;
        proto_upd = proto_reg;
        pend_cur  = is_tag(et_reg) && (int'(tags_reg) < MAX_TAGS);
        if (p == 8'(ETH_HDR_LEN - 1))
        begin
            et_upd = {prev_reg, in_data.data_byte};
        end
        else if (p >= 8'(ETH_HDR_LEN) && pend_cur)
        begin
            if (p == hs_wide + 8'(TAG_LEN - 1))
            begin
                et_upd   = {prev_reg, in_data.data_byte};
                hs_upd   = hs_reg + OFS_W'(TAG_LEN);
                tags_upd = tags_reg + 1'b1;
            end
        end
        else if (p >= 8'(ETH_HDR_LEN))
        begin
            if (et_reg == ET_IPV4 && p == hs_wide + 8'(IPV4_PROTO_OFS))
            begin
                proto_upd = in_data.data_byte;
            end
            else if (et_reg == ET_IPV6 && p == hs_wide + 8'(IPV6_NH_OFS))
            begin
                proto_upd = in_data.data_byte;
            end
        end
    end

    always_comb
    begin
        hs_nwide  = {1'b0, hs_upd};
        pend_new  = is_tag(et_upd) && (int'(tags_upd) < MAX_TAGS);
        too_short = (p < 8'(ETH_HDR_LEN - 1)) || pend_new;
        pkt_idx   = 8'd0;
        if (et_upd == ET_IPV4 && p >= hs_nwide + 8'(IPV4_HDR_LEN - 1))
        begin
            pkt_idx = proto_upd;
        end
        else if (et_upd == ET_IPV6 && p >= hs_nwide + 8'(IPV6_HDR_LEN - 1))
        begin
            pkt_idx = proto_upd;
        end
    end

    // next state of the parser
    always_comb
    begin
        ofs_next   = ofs_reg;
        et_next    = et_reg;
        tags_next  = tags_reg;
        hs_next    = hs_reg;
        proto_next = proto_reg;
        prev_next  = prev_reg;
        if (accept && in_data.operation == OP_BYTE)
        begin
            if (in_data.last_byte)
            begin
                ofs_next   = '0;
                et_next    = '0;
                tags_next  = '0;
                hs_next    = OFS_W'(ETH_HDR_LEN);
                proto_next = '0;
                prev_next  = '0;
            end
            else
            begin
                ofs_next   = (ofs_reg == '1) ? ofs_reg : ofs_reg + 1'b1;
                et_next    = et_upd;
                tags_next  = tags_upd;
                hs_next    = hs_upd;
                proto_next = proto_upd;
                prev_next  = in_data.data_byte;
            end
        end
    end

    // command to the back end
    always_comb
    begin
        cmd_push    = 1'b0;
        cmd.kind    = CMD_SKIP;
        cmd.idx     = 8'd0;
        cmd.verdict = action_reg;
        if (accept)
        begin
            if (in_data.operation == OP_READ)
            begin
                cmd_push    = 1'b1;
                cmd.kind    = CMD_READ;
                cmd.idx     = in_data.counter_index;
                cmd.verdict = 3'd0;
            end
            else if (in_data.last_byte)
            begin
                cmd_push = 1'b1;
                if (!too_short)
                begin
                    cmd.kind = CMD_COUNT;
                    cmd.idx  = pkt_idx;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ofs_reg    <= '0;
            et_reg     <= '0;
            tags_reg   <= '0;
            hs_reg     <= OFS_W'(ETH_HDR_LEN);
            proto_reg  <= '0;
            prev_reg   <= '0;
            action_reg <= ACTION_RESET;
        end
        else
        begin
            ofs_reg   <= ofs_next;
            et_reg    <= et_next;
            tags_reg  <= tags_next;
            hs_reg    <= hs_next;
            proto_reg <= proto_next;
            prev_reg  <= prev_next;
            if (cfg_valid)
            begin
                action_reg <= cfg_data;
            end
        end
    end

endmodule

// ===== hdl/epc_back.sv =====
// ----------------------------------------------------------------------------
// epc_back
// Counter store: reads the addressed counter, increments or returns it, and
// forms the result transaction.
// ----------------------------------------------------------------------------
module epc_back
    import epc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_empty,
    output logic      cmd_pop,
    input  cmd_t      cmd,
    input  logic      res_full,
    output logic      res_push,
    output out_item_t res
);

    logic [COUNT_BITS-1:0] mem [NUM_CNT];
    logic [NUM_CNT-1:0]    vld_reg;

    logic                  a_valid_reg;
    cmd_t                  a_cmd_reg;
    logic [COUNT_BITS-1:0] rd_reg;
    logic                  rdv_reg;

    logic                  lw_valid_reg;
    logic [7:0]            lw_idx_reg;
    logic [COUNT_BITS-1:0] lw_val_reg;

    logic                  a_fire;
    logic                  wr_en;
    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] sum;

    assign a_fire   = a_valid_reg && !res_full;
    assign cmd_pop  = !cmd_empty && (!a_valid_reg || a_fire);
    assign wr_en    = a_fire && (a_cmd_reg.kind == CMD_COUNT);
    assign res_push = a_fire;

    // last write covers the read issued in the same cycle
    assign cur = (lw_valid_reg && lw_idx_reg == a_cmd_reg.idx) ? lw_val_reg :
                 (rdv_reg ? rd_reg : '0);
    assign sum = cur + 1'b1;

    always_comb
    begin
        res.result_kind    = RES_VERDICT;
        res.verdict        = a_cmd_reg.verdict;
        res.was_counted    = 1'b0;
        res.protocol_index = 8'd0;
        res.count_value    = 64'd0;
        case (a_cmd_reg.kind)
            CMD_READ:
            begin
                res.result_kind    = RES_READ;
                res.verdict        = 3'd0;
                res.protocol_index = a_cmd_reg.idx;
                res.count_value    = 64'(cur);
            end
            CMD_COUNT:
            begin
                res.was_counted    = 1'b1;
                res.protocol_index = a_cmd_reg.idx;
                res.count_value    = 64'(sum);
            end
            default:
            begin
                res.was_counted = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            rd_reg    <= mem[cmd.idx];
            a_cmd_reg <= cmd;
        end
        if (wr_en)
        begin
            mem[a_cmd_reg.idx] <= sum;
            lw_idx_reg         <= a_cmd_reg.idx;
            lw_val_reg         <= sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            vld_reg      <= '0;
            rdv_reg      <= 1'b0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_pop)
            begin
                a_valid_reg <= 1'b1;
                rdv_reg     <= vld_reg[cmd.idx];
            end
            else if (a_fire)
            begin
                a_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                vld_reg[a_cmd_reg.idx] <= 1'b1;
                lw_valid_reg           <= 1'b1;
            end
        end
    end

endmodule

// ===== hdl/ethernet_protocol_counter.sv =====
// ----------------------------------------------------------------------------
// ethernet_protocol_counter
// Counts Ethernet packets per IP protocol number and returns a verdict per
// packet; counters can be read back through the same input queue.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-----------------------
//   input    | push / full           | in_data  (in_item_t)
//   result   | pop / empty           | out_data (out_item_t)
//   config   | cfg_valid / cfg_ready | cfg_data (packet_action)
//
// One byte or read transaction per cycle while full is low; a result reaches the
// result ports through the command queue, counter read stage and result queue.
// The counter memory reads one entry and writes one per cycle, so back to back
// transactions are sustained while the result queue is not full.
// Reset clears all counters at once through per-entry valid bits.
// A stalled result side fills the output and command queues, then full rises.
// ----------------------------------------------------------------------------
module ethernet_protocol_counter
    import epc_pkg::*;
#(
    parameter int MAX_TAGS   = MAX_TAGS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  in_data,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [2:0] cfg_data
);

    localparam int CMD_W = $bits(cmd_t);
    localparam int RES_W = $bits(out_item_t);

    logic       cmd_push, cmd_full, cmd_pop, cmd_empty;
    cmd_t       cmd_in, cmd_out;
    logic [CMD_W-1:0] cmd_q_data;
    logic       res_push, res_full;
    out_item_t  res;
    logic [RES_W-1:0] res_q_data;

    assign cfg_ready = 1'b1;
    assign cmd_out   = cmd_t'(cmd_q_data);
    assign out_data  = out_item_t'(res_q_data);

    epc_front #(
        .MAX_TAGS (MAX_TAGS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in),
        .cmd_full  (cmd_full)
    );

    epc_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_Q_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_q_data),
        .empty (cmd_empty)
    );

    epc_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd_out),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    epc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_Q_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_q_data),
        .empty (empty)
    );

endmodule

// ===== hdl/epc_checker.sv =====
// ----------------------------------------------------------------------------
// epc_checker
// Port-level checks of the protocol counter, bound to the top level.
// ----------------------------------------------------------------------------
`include "ethernet_protocol_counter_assert.svh"

module epc_checker
    import epc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      empty,
    input logic      pop,
    input out_item_t out_data
);

    // read transactions carry no verdict
    `EPC_ASSERT_NOW(a_read_no_verdict, clk, rst_n,
        !empty && out_data.result_kind == RES_READ,
        out_data.verdict == 3'd0 && !out_data.was_counted)

    // uncounted packets report index and value zero
    `EPC_ASSERT_NOW(a_skip_zero, clk, rst_n,
        !empty && out_data.result_kind == RES_VERDICT && !out_data.was_counted,
        out_data.protocol_index == 8'd0 && out_data.count_value == 64'd0)

    `EPC_ASSERT_NEXT(a_res_holds, clk, rst_n, !empty && !pop, !empty)

    `EPC_ASSERT_NEXT(a_res_stable, clk, rst_n, !empty && !pop, $stable(out_data))

endmodule

bind ethernet_protocol_counter epc_checker u_epc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
);
